// ----- sv/hpl_pkg.sv -----
package hpl_pkg;

    localparam int SLOTS   = 64;
    localparam int SIZE_W  = 3;
    localparam int WORD_W  = 32;

    localparam logic [SIZE_W-1:0] SIZE_LOG2_RST = 3'd6;
    localparam logic [SIZE_W-1:0] SIZE_LOG2_MIN = 3'd2;

    typedef logic [1:0]  func_t;
    typedef logic [1:0]  status_t;
    typedef logic [15:0] key_t;
    typedef logic [5:0]  slot_t;
    typedef logic [6:0]  count_t;

    localparam func_t FUNC_LOOKUP = 2'd0;
    localparam func_t FUNC_INSERT = 2'd1;
    localparam func_t FUNC_DELETE = 2'd2;

    localparam status_t ST_OK   = 2'd0;
    localparam status_t ST_MISS = 2'd1;
    localparam status_t ST_FULL = 2'd2;
    localparam status_t ST_ZERO = 2'd3;

    typedef struct packed {
        func_t func;
        key_t  port;
        key_t  flow_index;
    } req_t;

    typedef struct packed {
        status_t status;
        key_t    match_index;
        slot_t   slot;
        count_t  occupied;
        logic    last;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic walk;
        logic shift;
        logic fin;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic imm;
        logic walk_done;
        logic to_shift;
        logic shift_done;
        logic fin_done;
    } sts_t;

endpackage

// ----- sv/hpl_ram.sv -----
module hpl_ram #(
    parameter int WIDTH = hpl_pkg::WORD_W,
    parameter int DEPTH = hpl_pkg::SLOTS
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/hpl_ctrl.sv -----
module hpl_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  hpl_pkg::sts_t sts,
    output hpl_pkg::cmd_t cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_WALK  = 2'd1;
    localparam logic [1:0] S_SHIFT = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = sts.imm ? S_FIN : S_WALK;
                end
            end
            S_WALK:
            begin
                if (sts.to_shift)
                begin
                    state_next = S_SHIFT;
                end
                else if (sts.walk_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_SHIFT:
            begin
                if (sts.shift_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (sts.fin_done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign cmd.load  = (state_reg == S_IDLE) && req_valid;
    assign cmd.walk  = (state_reg == S_WALK);
    assign cmd.shift = (state_reg == S_SHIFT);
    assign cmd.fin   = (state_reg == S_FIN);

endmodule

// ----- sv/hpl_dp.sv -----
module hpl_dp #(
    parameter int SLOTS = hpl_pkg::SLOTS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  hpl_pkg::cmd_t              cmd,
    output hpl_pkg::sts_t              sts,
    input  hpl_pkg::req_t              req,
    input  logic                       cfg_valid,
    input  logic [hpl_pkg::SIZE_W-1:0] cfg_data,
    output logic                       rsp_valid,
    input  logic                       rsp_ready,
    output hpl_pkg::rsp_t              rsp
);

    localparam int AW     = $clog2(SLOTS);
    localparam int MAX_LG = $clog2(SLOTS + 1) - 1;

    typedef logic [AW-1:0] addr_t;

    logic [hpl_pkg::SIZE_W-1:0] size_log2_reg, size_log2_next;
    logic [hpl_pkg::SIZE_W-1:0] lg;
    logic [AW:0]                n_win;
    addr_t                      mask;
    addr_t                      home_in;
    addr_t                      home;

    hpl_pkg::func_t op_reg, op_next;
    hpl_pkg::key_t  port_key_reg, port_key_next;
    hpl_pkg::key_t  fidx_reg, fidx_next;

    addr_t       cur_reg, cur_next, cur_inc;
    logic [AW:0] step_reg, step_next;
    addr_t       hole_reg, hole_next;
    addr_t       k_home, dk, dj;

    logic [SLOTS-1:0] vld_reg, vld_next;
    logic             rvld_reg;

    logic                       ram_we;
    addr_t                      ram_waddr;
    logic [hpl_pkg::WORD_W-1:0] ram_wdata;
    logic [hpl_pkg::WORD_W-1:0] ram_rdata;
    logic [hpl_pkg::WORD_W-1:0] word;

    logic empty, at_end, walk_end, hit, is_key;
    logic lk_match, stall, emit_pend, emit_fin, to_shift;
    logic shift_end, move, advance, out_free, ins_write;

    logic            pend_valid_reg, pend_valid_next;
    hpl_pkg::key_t   pend_idx_reg, pend_idx_next;
    addr_t           pend_slot_reg, pend_slot_next;

    hpl_pkg::status_t fin_status_reg, fin_status_next;
    hpl_pkg::key_t    fin_index_reg, fin_index_next;
    addr_t            fin_slot_reg, fin_slot_next;

    hpl_pkg::count_t count_reg, count_next;

    logic          out_valid_reg, out_valid_next;
    hpl_pkg::rsp_t out_reg, out_next;

    hpl_ram #(
        .WIDTH (hpl_pkg::WORD_W),
        .DEPTH (SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (cur_next),
        .rdata (ram_rdata)
    );

    // window size: clamp the log2 to [2, 6] and to the largest power of two within SLOTS
    always_comb
    begin
        if (size_log2_reg < hpl_pkg::SIZE_LOG2_MIN)
        begin
            lg = hpl_pkg::SIZE_LOG2_MIN;
        end
        else if (size_log2_reg > hpl_pkg::SIZE_W'(MAX_LG))
        begin
            lg = hpl_pkg::SIZE_W'(MAX_LG);
        end
        else
        begin
            lg = size_log2_reg;
        end
        n_win = (AW + 1)'(1) << lg;
        mask  = addr_t'(n_win - 1'b1);
    end

    assign home_in = req.port[AW-1:0] & mask;
    assign home    = port_key_reg[AW-1:0] & mask;

    // read data always belongs to cur_reg
    assign word     = rvld_reg ? ram_rdata : '0;
    assign empty    = (word == '0);
    assign at_end   = (step_reg == n_win);
    assign walk_end = at_end || empty;
    assign hit      = (word[31:16] == port_key_reg);
    assign is_key   = (word == {port_key_reg, fidx_reg});
    assign cur_inc  = addr_t'(cur_reg + 1'b1) & mask;

    // backward shift test: move when home is not cyclically in (hole, cur]
    assign k_home = word[16 +: AW] & mask;
    assign dk     = addr_t'(k_home - hole_reg) & mask;
    assign dj     = addr_t'(cur_reg - hole_reg) & mask;

    assign out_free  = !out_valid_reg || rsp_ready;
    assign lk_match  = cmd.walk && (op_reg == hpl_pkg::FUNC_LOOKUP) && !walk_end && hit;
    assign stall     = lk_match && pend_valid_reg && !out_free;
    assign emit_pend = lk_match && pend_valid_reg && out_free;
    assign to_shift  = cmd.walk && (op_reg == hpl_pkg::FUNC_DELETE) && !walk_end && is_key;
    assign shift_end = at_end || empty;
    assign move      = cmd.shift && !shift_end && ((dk == '0) || (dk > dj));
    assign advance   = (cmd.walk && !walk_end && !stall) || (cmd.shift && !shift_end);
    assign emit_fin  = cmd.fin && out_free;
    assign ins_write = cmd.walk && (op_reg == hpl_pkg::FUNC_INSERT) && !at_end && empty;

    assign sts.imm        = ((req.func == hpl_pkg::FUNC_INSERT) && (req.port == '0))
                            || ((req.func != hpl_pkg::FUNC_LOOKUP)
                                && (req.func != hpl_pkg::FUNC_INSERT)
                                && (req.func != hpl_pkg::FUNC_DELETE));
    assign sts.walk_done  = cmd.walk && walk_end;
    assign sts.to_shift   = to_shift;
    assign sts.shift_done = cmd.shift && shift_end;
    assign sts.fin_done   = emit_fin;

    always_comb
    begin
        size_log2_next  = cfg_valid ? cfg_data : size_log2_reg;
        op_next         = op_reg;
        port_key_next   = port_key_reg;
        fidx_next       = fidx_reg;
        cur_next        = cur_reg;
        step_next       = step_reg;
        hole_next       = hole_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        pend_slot_next  = pend_slot_reg;
        fin_status_next = fin_status_reg;
        fin_index_next  = fin_index_reg;
        fin_slot_next   = fin_slot_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg && !rsp_ready;
        out_next        = out_reg;
        ram_we          = 1'b0;
        ram_waddr       = hole_reg;
        ram_wdata       = word;

        if (cmd.load)
        begin
            op_next         = req.func;
            port_key_next   = req.port;
            fidx_next       = req.flow_index;
            cur_next        = home_in;
            step_next       = '0;
            pend_valid_next = 1'b0;
            fin_status_next = (req.func == hpl_pkg::FUNC_INSERT) ? hpl_pkg::ST_ZERO
                                                                 : hpl_pkg::ST_MISS;
            fin_index_next  = '0;
            fin_slot_next   = '0;
        end
        else if (advance)
        begin
            cur_next  = cur_inc;
            step_next = to_shift ? (AW + 1)'(1) : step_reg + 1'b1;
        end

        if (lk_match && !stall)
        begin
            pend_valid_next = 1'b1;
            pend_idx_next   = word[15:0];
            pend_slot_next  = cur_reg;
        end

        if (sts.walk_done)
        begin
            priority if (op_reg == hpl_pkg::FUNC_LOOKUP)
            begin
                fin_status_next = pend_valid_reg ? hpl_pkg::ST_OK : hpl_pkg::ST_MISS;
                fin_index_next  = pend_valid_reg ? pend_idx_reg : '0;
                fin_slot_next   = pend_valid_reg ? pend_slot_reg : cur_reg;
            end
            else if (op_reg == hpl_pkg::FUNC_INSERT)
            begin
                fin_status_next = at_end ? hpl_pkg::ST_FULL : hpl_pkg::ST_OK;
                fin_index_next  = '0;
                fin_slot_next   = at_end ? home : cur_reg;
            end
            else
            begin
                fin_status_next = hpl_pkg::ST_MISS;
                fin_index_next  = '0;
                fin_slot_next   = cur_reg;
            end
        end

        if (to_shift)
        begin
            hole_next = cur_reg;
        end

        priority if (ins_write)
        begin
            ram_we     = 1'b1;
            ram_waddr  = cur_reg;
            ram_wdata  = {port_key_reg, fidx_reg};
            count_next = count_reg + 1'b1;
        end
        else if (move)
        begin
            ram_we    = 1'b1;
            hole_next = cur_reg;
        end
        else if (sts.shift_done)
        begin
            ram_we          = 1'b1;
            ram_wdata       = '0;
            count_next      = (count_reg != '0) ? count_reg - 1'b1 : count_reg;
            fin_status_next = hpl_pkg::ST_OK;
            fin_index_next  = '0;
            fin_slot_next   = hole_reg;
        end
        else
        begin
            ram_we = 1'b0;
        end

        vld_next = vld_reg;
        if (ram_we)
        begin
            vld_next[ram_waddr] = 1'b1;
        end

        // a lookup hands the previous match on; the final beat comes from FIN
        if (emit_pend)
        begin
            out_valid_next       = 1'b1;
            out_next.status      = hpl_pkg::ST_OK;
            out_next.match_index = pend_idx_reg;
            out_next.slot        = hpl_pkg::slot_t'(pend_slot_reg);
            out_next.occupied    = count_reg;
            out_next.last        = 1'b0;
        end
        else if (emit_fin)
        begin
            out_valid_next       = 1'b1;
            out_next.status      = fin_status_reg;
            out_next.match_index = fin_index_reg;
            out_next.slot        = hpl_pkg::slot_t'(fin_slot_reg);
            out_next.occupied    = count_reg;
            out_next.last        = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_log2_reg  <= hpl_pkg::SIZE_LOG2_RST;
            vld_reg        <= '0;
            rvld_reg       <= 1'b0;
            cur_reg        <= '0;
            step_reg       <= '0;
            pend_valid_reg <= 1'b0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            op_reg         <= hpl_pkg::FUNC_LOOKUP;
        end
        else
        begin
            size_log2_reg  <= size_log2_next;
            vld_reg        <= vld_next;
            rvld_reg       <= vld_reg[cur_next];
            cur_reg        <= cur_next;
            step_reg       <= step_next;
            pend_valid_reg <= pend_valid_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
            op_reg         <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        port_key_reg   <= port_key_next;
        fidx_reg       <= fidx_next;
        hole_reg       <= hole_next;
        pend_idx_reg   <= pend_idx_next;
        pend_slot_reg  <= pend_slot_next;
        fin_status_reg <= fin_status_next;
        fin_index_reg  <= fin_index_next;
        fin_slot_reg   <= fin_slot_next;
        out_reg        <= out_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= hpl_pkg::count_t'(SLOTS))
        else $error("entry count above table depth");

    a_write_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> ((ram_waddr & ~mask) == '0))
        else $error("store write outside the probe window");

    a_shift_ahead: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.shift && !shift_end) |-> (dj != '0))
        else $error("shift scan caught up with the hole");

    a_pend_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (op_reg == hpl_pkg::FUNC_LOOKUP))
        else $error("pending match outside a lookup");
`endif

endmodule

// ----- sv/port_hash_table_linear_probe.sv -----
// Open-addressed port table, linear probing, backward-shift delete. One request at a
// time: the beat is accepted, then the slot store is probed one slot per cycle through
// its single registered read port (unless a lookup holds its walk, see below), then
// the FIN state hands the final result to the output register. The walk covers the
// slots up to the first empty slot for lookup and insert (at most the whole window),
// and for delete the search plus the shift scan up to the next empty slot (at most
// twice the window size). The FIN state waits while the output register still holds
// an untaken beat. A lookup with several matches sends one beat per match and holds
// its walk while a second match waits behind an untaken beat. The store reads as
// empty right after reset (per-slot valid flags), so no clearing pass is needed.
// The size register may be written while no request is in flight.
module port_hash_table_linear_probe #(
    parameter int SLOTS = hpl_pkg::SLOTS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  hpl_pkg::req_t              req,
    output logic                       rsp_valid,
    input  logic                       rsp_ready,
    output hpl_pkg::rsp_t              rsp,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [hpl_pkg::SIZE_W-1:0] cfg_data
);

    hpl_pkg::cmd_t cmd;
    hpl_pkg::sts_t sts;

    assign cfg_ready = 1'b1;

    hpl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    hpl_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .req       (req),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

// ----- test/port_hash_table_linear_probe_tb.sv -----
module port_hash_table_linear_probe_tb;

    localparam hpl_pkg::func_t FUNC_UNUSED = 2'd3;
    localparam int    HOLD_CYCLES = 300;
    localparam int    SETTLE_CYCLES = 4;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                       req_valid = 1'b0;
    logic                       req_ready;
    hpl_pkg::req_t              req = '0;
    logic                       rsp_valid;
    logic                       rsp_ready = 1'b0;
    hpl_pkg::rsp_t              rsp;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [hpl_pkg::SIZE_W-1:0] cfg_data = '0;

    // shadow of the slot store, entry count and size register
    logic [hpl_pkg::WORD_W-1:0] table_shadow [hpl_pkg::SLOTS];
    hpl_pkg::count_t            shadow_count;
    logic [hpl_pkg::SIZE_W-1:0] shadow_size_log2;
    hpl_pkg::rsp_t              pending_rsp [$];

    int send_idle_pct = 0;
    int stall_pct = 0;
    int n_err = 0;

    // long receiver hold-off: request count vs. taken count
    int hold_req = 0;
    int hold_taken = 0;
    int hold_left = 0;

    hpl_pkg::rsp_t want_rsp;

    port_hash_table_linear_probe dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic int window_slots();
        int l;
        l = shadow_size_log2;
        if (l < 2)
            l = 2;
        if (l > 6)
            l = 6;
        while (l > 0 && (1 << l) > hpl_pkg::SLOTS)
            l--;
        return 1 << l;
    endfunction

    function automatic hpl_pkg::rsp_t make_rsp(hpl_pkg::status_t st, hpl_pkg::key_t idx,
                                               int s, logic lst);
        hpl_pkg::rsp_t r;
        r.status      = st;
        r.match_index = idx;
        r.slot        = hpl_pkg::slot_t'(s);
        r.occupied    = shadow_count;
        r.last        = lst;
        return r;
    endfunction

    // apply one accepted operation to the shadow table and queue its results
    function automatic void apply_table_op(hpl_pkg::req_t r);
        int n, m, home, h, i, e, j, k, dk, dj;
        logic [hpl_pkg::WORD_W-1:0] w, key;
        hpl_pkg::rsp_t held;
        bit have_held;
        n = window_slots();
        m = n - 1;
        home = r.port & m;
        h = home;
        have_held = 1'b0;
        case (r.func)
            hpl_pkg::FUNC_LOOKUP:
            begin
                for (i = 0; i < n; i++)
                begin
                    w = table_shadow[h];
                    if (w == '0)
                        break;
                    if (w[31:16] == r.port)
                    begin
                        if (have_held)
                            pending_rsp.push_back(held);
                        held = make_rsp(hpl_pkg::ST_OK, w[15:0], h, 1'b0);
                        have_held = 1'b1;
                    end
                    h = (h + 1) & m;
                end
                if (have_held)
                begin
                    held.last = 1'b1;
                    pending_rsp.push_back(held);
                end
                else
                    pending_rsp.push_back(make_rsp(hpl_pkg::ST_MISS, '0, h, 1'b1));
            end
            hpl_pkg::FUNC_INSERT:
            begin
                if (r.port == '0)
                    pending_rsp.push_back(make_rsp(hpl_pkg::ST_ZERO, '0, 0, 1'b1));
                else
                begin
                    for (i = 0; i < n; i++)
                    begin
                        if (table_shadow[h] == '0)
                            break;
                        h = (h + 1) & m;
                    end
                    if (i < n)
                    begin
                        table_shadow[h] = {r.port, r.flow_index};
                        shadow_count = shadow_count + 1'b1;
                        pending_rsp.push_back(make_rsp(hpl_pkg::ST_OK, '0, h, 1'b1));
                    end
                    else
                        pending_rsp.push_back(make_rsp(hpl_pkg::ST_FULL, '0, home, 1'b1));
                end
            end
            hpl_pkg::FUNC_DELETE:
            begin
                key = {r.port, r.flow_index};
                for (i = 0; i < n; i++)
                begin
                    w = table_shadow[h];
                    if (w == '0 || w == key)
                        break;
                    h = (h + 1) & m;
                end
                if (i >= n || table_shadow[h] == '0 || table_shadow[h] != key)
                    pending_rsp.push_back(make_rsp(hpl_pkg::ST_MISS, '0, h, 1'b1));
                else
                begin
                    // backward shift: pull an entry into the hole unless its home
                    // lies cyclically in (hole, current]
                    e = h;
                    j = (e + 1) & m;
                    for (i = 1; i < n; i++)
                    begin
                        w = table_shadow[j];
                        if (w == '0)
                            break;
                        k = w[31:16] & m;
                        dk = (k - e) & m;
                        dj = (j - e) & m;
                        if (dk == 0 || dk > dj)
                        begin
                            table_shadow[e] = w;
                            e = j;
                        end
                        j = (j + 1) & m;
                    end
                    table_shadow[e] = '0;
                    if (shadow_count > 0)
                        shadow_count = shadow_count - 1'b1;
                    pending_rsp.push_back(make_rsp(hpl_pkg::ST_OK, '0, e, 1'b1));
                end
            end
            default:
                pending_rsp.push_back(make_rsp(hpl_pkg::ST_MISS, '0, 0, 1'b1));
        endcase
    endfunction

    function automatic hpl_pkg::key_t rand_port();
        case ($urandom_range(9))
            0: return hpl_pkg::key_t'($urandom);
            1: return $urandom_range(1) ? 16'hffff : 16'h0000;
            // small pool: shared homes and repeated ports
            default: return hpl_pkg::key_t'(($urandom_range(3) << 14) | $urandom_range(7));
        endcase
    endfunction

    function automatic hpl_pkg::req_t rand_req();
        hpl_pkg::req_t r;
        int n, s, roll, ins_pct;
        int live [$];
        n = window_slots();
        for (s = 0; s < n; s++)
            if (table_shadow[s] != '0)
                live.push_back(s);
        ins_pct = (live.size() * 4 < n * 3) ? 40 : 15;
        r.port = rand_port();
        r.flow_index = hpl_pkg::key_t'($urandom);
        roll = $urandom_range(99);
        if (roll < 3)
            r.func = FUNC_UNUSED;
        else if (roll < 33)
            r.func = hpl_pkg::FUNC_LOOKUP;
        else if (roll < 33 + ins_pct)
            r.func = hpl_pkg::FUNC_INSERT;
        else
            r.func = hpl_pkg::FUNC_DELETE;
        // mostly target live entries so lookups hit and deletes shift
        if (live.size() > 0 && r.func != hpl_pkg::FUNC_INSERT && $urandom_range(99) < 70)
        begin
            s = live[$urandom_range(live.size() - 1)];
            r.port = table_shadow[s][31:16];
            if (r.func == hpl_pkg::FUNC_DELETE)
                r.flow_index = table_shadow[s][15:0];
        end
        return r;
    endfunction

    task automatic send_op(input hpl_pkg::func_t f, input hpl_pkg::key_t p,
                           input hpl_pkg::key_t fi);
        hpl_pkg::req_t r;
        r.func = f;
        r.port = p;
        r.flow_index = fi;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        apply_table_op(r);
    endtask

    task automatic send_random(input int count);
        hpl_pkg::req_t r;
        repeat (count)
        begin
            r = rand_req();
            send_op(r.func, r.port, r.flow_index);
        end
    endtask

    task automatic wait_idle();
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_size(input logic [hpl_pkg::SIZE_W-1:0] v);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        shadow_size_log2 = v;
        cfg_valid <= 1'b0;
    endtask

    task automatic test_directed();
        send_op(hpl_pkg::FUNC_LOOKUP, 16'h1234, 16'h0000);   // empty table
        send_op(hpl_pkg::FUNC_INSERT, 16'h0000, 16'h0005);   // zero port rejected
        send_op(hpl_pkg::FUNC_DELETE, 16'h1234, 16'h0000);   // delete on empty
        send_op(hpl_pkg::FUNC_INSERT, 16'hffff, 16'hffff);
        send_op(hpl_pkg::FUNC_INSERT, 16'h0001, 16'h0000);
        send_op(hpl_pkg::FUNC_INSERT, 16'h0041, 16'h1111);   // collides with 0x0001
        send_op(hpl_pkg::FUNC_INSERT, 16'h0041, 16'h2222);   // duplicate port
        send_op(hpl_pkg::FUNC_INSERT, 16'h0081, 16'h3333);
        send_op(hpl_pkg::FUNC_INSERT, 16'hffbf, 16'h0001);   // probe wraps past top slot
        send_op(hpl_pkg::FUNC_LOOKUP, 16'h0041, 16'hffff);   // two matches
        send_op(hpl_pkg::FUNC_LOOKUP, 16'hffff, 16'h0000);
        send_op(hpl_pkg::FUNC_LOOKUP, 16'h0000, 16'h0000);
        send_op(hpl_pkg::FUNC_DELETE, 16'h0041, 16'h1111);   // gap closed by shifting
        send_op(hpl_pkg::FUNC_DELETE, 16'h0041, 16'h9999);   // port present, index not
        send_op(FUNC_UNUSED, 16'h0041, 16'h2222);
        send_op(hpl_pkg::FUNC_DELETE, 16'hffff, 16'hffff);   // shift across the wrap
        send_op(hpl_pkg::FUNC_LOOKUP, 16'h0041, 16'h0000);
    endtask

    task automatic test_full_window();
        logic [hpl_pkg::WORD_W-1:0] w;
        write_size(3'd1);   // clamps to four slots
        send_op(hpl_pkg::FUNC_INSERT, 16'h0100, 16'h0001);
        send_op(hpl_pkg::FUNC_INSERT, 16'h0200, 16'h0002);
        send_op(hpl_pkg::FUNC_INSERT, 16'h0101, 16'h0003);
        send_op(hpl_pkg::FUNC_INSERT, 16'h0302, 16'h0004);
        send_op(hpl_pkg::FUNC_INSERT, 16'h0103, 16'h0005);   // window full
        send_op(hpl_pkg::FUNC_LOOKUP, 16'h0500, 16'h0000);   // walk whole window, no empty
        send_op(hpl_pkg::FUNC_DELETE, 16'h0500, 16'h0000);
        w = table_shadow[1];
        send_op(hpl_pkg::FUNC_DELETE, w[31:16], w[15:0]);    // shift scan in a full window
        write_size(3'd0);
        send_op(hpl_pkg::FUNC_INSERT, 16'h0203, 16'h0006);
        write_size(3'd7);   // clamps to 64 slots
        send_op(hpl_pkg::FUNC_LOOKUP, 16'h0100, 16'h0000);
    endtask

    task automatic test_random_phase(input int count, input int idle_pct,
                                     input int stall,
                                     input logic [hpl_pkg::SIZE_W-1:0] sz);
        write_size(sz);
        send_idle_pct = idle_pct;
        stall_pct = stall;
        send_random(count);
        send_idle_pct = 0;
        stall_pct = 0;
    endtask

    task automatic test_backpressure();
        int i;
        write_size(3'd6);
        for (i = 0; i < 6; i++)
            send_op(hpl_pkg::FUNC_INSERT, 16'h0a05, hpl_pkg::key_t'($urandom));
        hold_req <= hold_req + 1;
        // keep offering while the output is held; input backs up behind it
        for (i = 0; i < 20; i++)
        begin
            if (i % 3 == 0)
                send_op(hpl_pkg::FUNC_LOOKUP, 16'h0a05, 16'h0000);
            else
                send_random(1);
        end
        // sender pauses until everything is back
        req_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        send_random(10);
    endtask

    always @(posedge clk)
    begin
        if (hold_req != hold_taken)
        begin
            hold_taken <= hold_req;
            hold_left <= HOLD_CYCLES;
            rsp_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                $error("unexpected result beat: %p", rsp);
                n_err++;
            end
            else
            begin
                want_rsp = pending_rsp.pop_front();
                if (rsp.status !== want_rsp.status)
                begin
                    $error("status: expected %0d, got %0d", want_rsp.status, rsp.status);
                    n_err++;
                end
                if (rsp.match_index !== want_rsp.match_index)
                begin
                    $error("match_index: expected %h, got %h",
                           want_rsp.match_index, rsp.match_index);
                    n_err++;
                end
                if (rsp.slot !== want_rsp.slot)
                begin
                    $error("slot: expected %0d, got %0d", want_rsp.slot, rsp.slot);
                    n_err++;
                end
                if (rsp.occupied !== want_rsp.occupied)
                begin
                    $error("occupied: expected %0d, got %0d",
                           want_rsp.occupied, rsp.occupied);
                    n_err++;
                end
                if (rsp.last !== want_rsp.last)
                begin
                    $error("last: expected %0d, got %0d", want_rsp.last, rsp.last);
                    n_err++;
                end
            end
        end
    end

    initial
    begin
        for (int s = 0; s < hpl_pkg::SLOTS; s++)
            table_shadow[s] = '0;
        shadow_count = '0;
        shadow_size_log2 = hpl_pkg::SIZE_LOG2_RST;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_window();
        test_random_phase(45, 0, 0, 3'd6);
        test_random_phase(60, 58, 0, 3'd3);
        test_random_phase(60, 0, 58, 3'd2);
        test_random_phase(60, 37, 37, 3'd5);
        test_random_phase(40, 0, 0, 3'd4);
        test_backpressure();

        wait_idle();
        repeat (20) @(posedge clk);
        if (n_err == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
